// File: rtl/core/ils_pkg.sv
`timescale 1ns / 1ps

package ils_pkg;

   // default sizing
   localparam int ILS_CAPACITY   = 64;
   localparam int ILS_DATA_WIDTH = 32;

   // operation codes
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_WRITE  = 3'd3;
   localparam logic [2:0] OP_SEARCH = 3'd4;

   // result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // memory read address select
   localparam logic [1:0] RD_POS    = 2'd0;
   localparam logic [1:0] RD_IDX    = 2'd1;
   localparam logic [1:0] RD_IDX_M1 = 2'd2;
   localparam logic [1:0] RD_IDX_P1 = 2'd3;

   // walk index update
   localparam logic [2:0] IDX_HOLD    = 3'd0;
   localparam logic [2:0] IDX_LD_CNT  = 3'd1;
   localparam logic [2:0] IDX_LD_POS  = 3'd2;
   localparam logic [2:0] IDX_LD_ZERO = 3'd3;
   localparam logic [2:0] IDX_INC     = 3'd4;
   localparam logic [2:0] IDX_DEC     = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       stat_load;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic       wr_value;     // 1: item value at position, 0: read data at index
      logic [2:0] idx_op;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       take_result;
      logic       set_hit;
      logic       out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] op;
      logic       stat_ok;
      logic       idx_eq_pos;
      logic       rem_done;
      logic       srch_done;
      logic       match;
   } sts_type;

endpackage

// File: rtl/core/ils_datapath.sv
`timescale 1ns / 1ps

module ils_datapath import ils_pkg::*; #(
   parameter  int CAPACITY   = ILS_CAPACITY,
   parameter  int DATA_WIDTH = ILS_DATA_WIDTH,
   localparam int CW         = $clog2(CAPACITY + 1),
   localparam int AW         = $clog2(CAPACITY)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output sts_type                      sts,
   input  logic [2:0]                   req_operation,
   input  logic [CW-1:0]                req_position,
   input  logic signed [DATA_WIDTH-1:0] req_item_value,
   output logic signed [DATA_WIDTH-1:0] rsp_out_value,
   output logic                         rsp_found,
   output logic [1:0]                   rsp_status,
   output logic [CW-1:0]                rsp_element_count,
   output logic                         rsp_is_empty
);

   logic [DATA_WIDTH-1:0] entries_mem [CAPACITY];

   logic [2:0]            op_ff;
   logic [CW-1:0]         pos_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [CW-1:0]         cnt_ff;
   logic [CW-1:0]         idx_ff;
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic [DATA_WIDTH-1:0] result_ff;
   logic                  hit_ff;
   logic [1:0]            stat_ff;
   logic [1:0]            stat_in;
   logic [CW-1:0]         rd_full;
   logic [CW-1:0]         wr_full;
   logic [CW:0]           idx_next;

   // classify the held item against the current count
   always_comb begin
      case (op_ff)
         OP_INSERT: begin
            if (pos_ff > cnt_ff)
               stat_in = STAT_RANGE;
            else if (cnt_ff == CW'(CAPACITY))
               stat_in = STAT_FULL;
            else
               stat_in = STAT_OK;
         end
         OP_REMOVE, OP_READ, OP_WRITE: begin
            stat_in = (pos_ff >= cnt_ff) ? STAT_RANGE : STAT_OK;
         end
         default: stat_in = STAT_OK;
      endcase
   end

   assign idx_next = {1'b0, idx_ff} + (CW+1)'(1);

   always_comb begin
      sts.op         = op_ff;
      sts.stat_ok    = (stat_in == STAT_OK);
      sts.idx_eq_pos = (idx_ff == pos_ff);
      sts.rem_done   = (idx_next >= {1'b0, cnt_ff});
      sts.srch_done  = (idx_ff >= cnt_ff);
      sts.match      = (rdata_ff == val_ff);
   end

   // select memory addresses
   always_comb begin
      case (cmd.rd_sel)
         RD_POS:    rd_full = pos_ff;
         RD_IDX:    rd_full = idx_ff;
         RD_IDX_M1: rd_full = idx_ff - CW'(1);
         RD_IDX_P1: rd_full = idx_next[CW-1:0];
         default:   rd_full = idx_ff;
      endcase
      wr_full = cmd.wr_value ? pos_ff : idx_ff;
   end

   // entry storage, registered read
   always_ff @(posedge clock) begin
      if (cmd.rd_en)
         rdata_ff <= entries_mem[rd_full[AW-1:0]];
      if (cmd.wr_en)
         entries_mem[wr_full[AW-1:0]] <= cmd.wr_value ? val_ff : rdata_ff;
   end

   // hold the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_operation;
         pos_ff <= req_position;
         val_ff <= req_item_value;
      end
   end

   // element count
   always_ff @(posedge clock) begin
      if (reset)
         cnt_ff <= '0;
      else if (cmd.cnt_inc)
         cnt_ff <= cnt_ff + CW'(1);
      else if (cmd.cnt_dec)
         cnt_ff <= cnt_ff - CW'(1);
   end

   // walk index
   always_ff @(posedge clock) begin
      case (cmd.idx_op)
         IDX_LD_CNT:  idx_ff <= cnt_ff;
         IDX_LD_POS:  idx_ff <= pos_ff;
         IDX_LD_ZERO: idx_ff <= '0;
         IDX_INC:     idx_ff <= idx_next[CW-1:0];
         IDX_DEC:     idx_ff <= idx_ff - CW'(1);
         default:     idx_ff <= idx_ff;
      endcase
   end

   // working result of the current item
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         result_ff <= '0;
         hit_ff    <= 1'b0;
      end else begin
         if (cmd.take_result)
            result_ff <= rdata_ff;
         if (cmd.set_hit)
            hit_ff <= 1'b1;
      end
      if (cmd.stat_load)
         stat_ff <= stat_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_out_value     <= result_ff;
         rsp_found         <= hit_ff;
         rsp_status        <= stat_ff;
         rsp_element_count <= cnt_ff;
         rsp_is_empty      <= (cnt_ff == '0);
      end
   end

endmodule

// File: rtl/core/ils_control.sv
`timescale 1ns / 1ps

module ils_control import ils_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_INS_CHK  = 4'd2;
   localparam logic [3:0] S_INS_WR   = 4'd3;
   localparam logic [3:0] S_REM_CAP  = 4'd4;
   localparam logic [3:0] S_REM_CHK  = 4'd5;
   localparam logic [3:0] S_REM_WR   = 4'd6;
   localparam logic [3:0] S_RD_CAP   = 4'd7;
   localparam logic [3:0] S_SRCH_CHK = 4'd8;
   localparam logic [3:0] S_SRCH_CMP = 4'd9;
   localparam logic [3:0] S_FINISH   = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequence one item
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.stat_load = 1'b1;
            state_in      = S_FINISH;
            case (sts.op)
               OP_INSERT: begin
                  if (sts.stat_ok) begin
                     cmd.idx_op = IDX_LD_CNT;
                     state_in   = S_INS_CHK;
                  end
               end
               OP_REMOVE: begin
                  if (sts.stat_ok) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_POS;
                     cmd.idx_op = IDX_LD_POS;
                     state_in   = S_REM_CAP;
                  end
               end
               OP_READ: begin
                  if (sts.stat_ok) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_POS;
                     state_in   = S_RD_CAP;
                  end
               end
               OP_WRITE: begin
                  if (sts.stat_ok) begin
                     cmd.wr_en    = 1'b1;
                     cmd.wr_value = 1'b1;
                  end
               end
               OP_SEARCH: begin
                  cmd.idx_op = IDX_LD_ZERO;
                  state_in   = S_SRCH_CHK;
               end
               default: state_in = S_FINISH;
            endcase
         end
         // move entries up from the top until the gap reaches the position
         S_INS_CHK: begin
            if (sts.idx_eq_pos) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_value = 1'b1;
               cmd.cnt_inc  = 1'b1;
               state_in     = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_M1;
               state_in   = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.idx_op = IDX_DEC;
            state_in   = S_INS_CHK;
         end
         S_REM_CAP: begin
            cmd.take_result = 1'b1;
            state_in        = S_REM_CHK;
         end
         // close the gap by moving later entries down
         S_REM_CHK: begin
            if (sts.rem_done) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_P1;
               state_in   = S_REM_WR;
            end
         end
         S_REM_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.idx_op = IDX_INC;
            state_in   = S_REM_CHK;
         end
         S_RD_CAP: begin
            cmd.take_result = 1'b1;
            state_in        = S_FINISH;
         end
         // scan stored entries from the front
         S_SRCH_CHK: begin
            if (sts.srch_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX;
               state_in   = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (sts.match) begin
               cmd.set_hit = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_SRCH_CHK;
            end
         end
         // wait for a free output register
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid: set on load, drop when taken
   always_comb begin
      if (cmd.out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/indexed_list_store.sv
`timescale 1ns / 1ps

// Ordered store of up to CAPACITY signed values, addressed by element index.
// Request channel (req_valid/req_ready) carries one item: an operation
// (insert, remove, read, write, search), a position and a value. Result
// channel (rsp_valid/rsp_ready) returns exactly one item per request: the
// removed or read value, a found flag, a status, the count and an empty flag.
// One item is in work at a time; the entries sit in a single-port memory
// with a registered read, and insert, remove and search walk it one entry
// at a time: a read state, then a write or compare state for each entry.
// The result turns valid in the same cycle that req_ready rises again.
// The result sits in an output register: if the receiver stalls, the next
// item is still accepted and worked on, and it waits only for that register.
// Reset clears the count and the control state; the store is then empty
// and ready at once. Entry contents are not cleared.

module indexed_list_store import ils_pkg::*; #(
   parameter  int CAPACITY   = ILS_CAPACITY,
   parameter  int DATA_WIDTH = ILS_DATA_WIDTH,
   localparam int CW         = $clog2(CAPACITY + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_operation,
   input  logic [CW-1:0]                req_position,
   input  logic signed [DATA_WIDTH-1:0] req_item_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_out_value,
   output logic                         rsp_found,
   output logic [1:0]                   rsp_status,
   output logic [CW-1:0]                rsp_element_count,
   output logic                         rsp_is_empty
);

   cmd_type cmd;
   sts_type sts;

   ils_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ils_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_position      (req_position),
      .req_item_value    (req_item_value),
      .rsp_out_value     (rsp_out_value),
      .rsp_found         (rsp_found),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .rsp_is_empty      (rsp_is_empty)
   );

endmodule

// File: tb/indexed_list_store_tb.sv
`timescale 1ns / 1ps

module indexed_list_store_tb;
   import ils_pkg::*;

   localparam int CAP       = ILS_CAPACITY;
   localparam int DW        = ILS_DATA_WIDTH;
   localparam int CW        = $clog2(CAP + 1);
   localparam int POS_MAX   = (1 << CW) - 1;
   localparam int CYCLE_CAP = 2000000;
   localparam int TAIL_WAIT = 4 * CAP;

   // spare operation codes, decoded as no-ops
   localparam logic [2:0] OP_SPARE_A = 3'd5;
   localparam logic [2:0] OP_SPARE_B = 3'd6;
   localparam logic [2:0] OP_SPARE_C = 3'd7;

   typedef struct packed {
      logic signed [DW-1:0] value;
      logic                 found;
      logic [1:0]           status;
      logic [CW-1:0]        count;
      logic                 empty;
   } list_result_type;

   typedef struct {
      logic [2:0]      op;
      logic [CW-1:0]   pos;
      logic [DW-1:0]   val;
      bit              typed;
      list_result_type want;
   } list_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [2:0]           req_operation = OP_SEARCH;
   logic [CW-1:0]        req_position = '0;
   logic signed [DW-1:0] req_item_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [DW-1:0] rsp_out_value;
   logic                 rsp_found;
   logic [1:0]           rsp_status;
   logic [CW-1:0]        rsp_element_count;
   logic                 rsp_is_empty;

   // shadow copy of the store
   logic [DW-1:0] shadow_entries [CAP];
   int            shadow_count = 0;

   list_result_type pending_results [$];
   list_row_type    directed_rows [$];
   int              mismatches = 0;
   int              cycle_count = 0;
   int              stall_left = 0;
   bit              idle_on = 1'b1;

   indexed_list_store dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_position      (req_position),
      .req_item_value    (req_item_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_value     (rsp_out_value),
      .rsp_found         (rsp_found),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .rsp_is_empty      (rsp_is_empty)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // apply one operation to the shadow store and return its result item
   function automatic list_result_type apply_list_op(logic [2:0] op, logic [CW-1:0] pos,
                                                     logic [DW-1:0] val);
      list_result_type r;
      int              p;
      int              i;
      r = '0;
      p = pos;
      case (op)
         OP_INSERT: begin
            if (p > shadow_count) begin
               r.status = STAT_RANGE;
            end else if (shadow_count >= CAP) begin
               r.status = STAT_FULL;
            end else begin
               for (i = shadow_count; i > p; i--) shadow_entries[i] = shadow_entries[i - 1];
               shadow_entries[p] = val;
               shadow_count++;
            end
         end
         OP_REMOVE: begin
            if (p >= shadow_count) begin
               r.status = STAT_RANGE;
            end else begin
               r.value = shadow_entries[p];
               for (i = p; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
               shadow_count--;
            end
         end
         OP_READ: begin
            if (p >= shadow_count) r.status = STAT_RANGE;
            else r.value = shadow_entries[p];
         end
         OP_WRITE: begin
            if (p >= shadow_count) r.status = STAT_RANGE;
            else shadow_entries[p] = val;
         end
         OP_SEARCH: begin
            for (i = 0; i < shadow_count; i++) begin
               if (shadow_entries[i] == val) r.found = 1'b1;
            end
         end
         default: ;
      endcase
      r.count = CW'(shadow_count);
      r.empty = (shadow_count == 0);
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      if (mismatches < 40)
         $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      mismatches++;
   endtask

   // drive one item and hold it until accepted; leave valid high
   task automatic send_item(logic [2:0] op, logic [CW-1:0] pos, logic [DW-1:0] val,
                            bit typed, list_result_type typed_want);
      list_result_type predicted;
      req_operation  = op;
      req_position   = pos;
      req_item_value = val;
      req_valid      = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_list_op(op, pos, val);
      pending_results.push_back(typed ? typed_want : predicted);
      @(negedge clock);
   endtask

   // drop valid for a random burst now and then
   task automatic sender_gap();
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   // hold off the sender until every result item has come back
   task automatic wait_all_results();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic add_row(logic [2:0] op, int pos, logic [DW-1:0] val);
      list_row_type row;
      row.op    = op;
      row.pos   = CW'(pos);
      row.val   = val;
      row.typed = 1'b0;
      row.want  = '0;
      directed_rows.push_back(row);
   endtask

   task automatic add_typed(logic [2:0] op, int pos, logic [DW-1:0] val,
                            logic [DW-1:0] value, logic found, logic [1:0] status,
                            int count, logic empty);
      list_row_type row;
      row.op    = op;
      row.pos   = CW'(pos);
      row.val   = val;
      row.typed = 1'b1;
      row.want  = '{value, found, status, CW'(count), empty};
      directed_rows.push_back(row);
   endtask

   // pick a random item with the given operation weights and send it
   task automatic send_random(int w_ins, int w_rem, int w_rd, int w_wr, int w_srch);
      int            roll;
      int            pos;
      logic [2:0]    op;
      logic [DW-1:0] val;
      roll = $urandom_range(0, w_ins + w_rem + w_rd + w_wr + w_srch - 1);
      if ($urandom_range(0, 39) == 0) op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
      else if (roll < w_ins) op = OP_INSERT;
      else if (roll < w_ins + w_rem) op = OP_REMOVE;
      else if (roll < w_ins + w_rem + w_rd) op = OP_READ;
      else if (roll < w_ins + w_rem + w_rd + w_wr) op = OP_WRITE;
      else op = OP_SEARCH;

      // mostly in-range positions, some anywhere in the field
      if ($urandom_range(0, 7) == 0) pos = $urandom_range(0, POS_MAX);
      else if (op == OP_INSERT) pos = $urandom_range(0, shadow_count);
      else if (shadow_count > 0) pos = $urandom_range(0, shadow_count - 1);
      else pos = 0;

      // mix extremes, a small pool and stored values so searches hit
      case ($urandom_range(0, 9))
         0: val = {1'b0, {(DW - 1){1'b1}}};
         1: val = {1'b1, {(DW - 1){1'b0}}};
         2, 3, 4: val = DW'($urandom_range(0, 15));
         5, 6: begin
            if (shadow_count > 0) val = shadow_entries[$urandom_range(0, shadow_count - 1)];
            else val = $urandom;
         end
         default: val = $urandom;
      endcase

      sender_gap();
      send_item(op, CW'(pos), val, 1'b0, '0);
   endtask

   // receiver: stall in random bursts while idling is on
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each accepted result item with the oldest pending one
   always @(posedge clock) begin : check_result
      list_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unrequested result item", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_value !== want.value)
               report_mismatch("out_value", rsp_out_value, want.value);
            if (rsp_found !== want.found) report_mismatch("found", rsp_found, want.found);
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_element_count !== want.count)
               report_mismatch("element_count", rsp_element_count, want.count);
            if (rsp_is_empty !== want.empty)
               report_mismatch("is_empty", rsp_is_empty, want.empty);
         end
      end
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      // empty store: everything indexed is out of range
      add_typed(OP_READ,   0, 0, 0, 0, STAT_RANGE, 0, 1);
      add_typed(OP_REMOVE, 0, 0, 0, 0, STAT_RANGE, 0, 1);
      add_typed(OP_WRITE,  0, 5, 0, 0, STAT_RANGE, 0, 1);
      add_typed(OP_SEARCH, 0, 0, 0, 0, STAT_OK,    0, 1);
      add_typed(OP_INSERT, 1, 9, 0, 0, STAT_RANGE, 0, 1);
      add_typed(OP_INSERT, POS_MAX, 9, 0, 0, STAT_RANGE, 0, 1);
      // extremes at both ends, then an insert at the head
      add_typed(OP_INSERT, 0, 32'h7fffffff, 0, 0, STAT_OK, 1, 0);
      add_typed(OP_INSERT, 1, 32'h80000000, 0, 0, STAT_OK, 2, 0);
      add_typed(OP_INSERT, 0, 0, 0, 0, STAT_OK, 3, 0);
      add_typed(OP_READ,   1, 0, 32'h7fffffff, 0, STAT_OK, 3, 0);
      add_typed(OP_READ,   2, 0, 32'h80000000, 0, STAT_OK, 3, 0);
      add_typed(OP_READ,   3, 0, 0, 0, STAT_RANGE, 3, 0);
      add_row(OP_WRITE,  0, 32'hffffffff);
      add_row(OP_SEARCH, 0, 32'hffffffff);
      add_row(OP_SEARCH, 0, 0);
      add_row(OP_SEARCH, POS_MAX, 32'h80000000);
      // spare codes leave the store alone
      add_typed(OP_SPARE_A, 0, 0, 0, 0, STAT_OK, 3, 0);
      add_typed(OP_SPARE_B, POS_MAX, 32'hffffffff, 0, 0, STAT_OK, 3, 0);
      add_typed(OP_SPARE_C, 1, 32'h12345678, 0, 0, STAT_OK, 3, 0);
      add_row(OP_REMOVE, 1, 123);
      add_typed(OP_REMOVE, 5, 0, 0, 0, STAT_RANGE, 2, 0);
      add_row(OP_READ,   0, 32'haaaaaaaa);
      add_row(OP_REMOVE, 0, 0);
      add_row(OP_REMOVE, 0, 32'h55555555);
      add_row(OP_SEARCH, 0, 32'h55555555);

      // hold reset, then release it on a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[k]) begin
         sender_gap();
         send_item(directed_rows[k].op, directed_rows[k].pos, directed_rows[k].val,
                   directed_rows[k].typed, directed_rows[k].want);
      end

      // balanced traffic
      repeat (500) send_random(3, 2, 2, 2, 2);

      // fill to capacity, then push against the full store
      while (shadow_count < CAP) send_random(8, 1, 1, 1, 1);
      send_item(OP_INSERT, CW'(CAP), $urandom, 1'b0, '0);
      send_item(OP_INSERT, CW'(CAP + 1), $urandom, 1'b0, '0);
      send_item(OP_INSERT, '0, $urandom, 1'b0, '0);
      repeat (150) send_random(8, 1, 2, 2, 3);

      // pause the sender until the block has answered everything
      wait_all_results();

      // drain to empty and keep poking the empty store
      while (shadow_count > 0) send_random(1, 8, 1, 1, 1);
      repeat (100) send_random(1, 4, 2, 2, 2);

      // search-heavy traffic over a mid-sized store
      while (shadow_count < CAP / 2) send_random(8, 1, 1, 1, 1);
      repeat (300) send_random(2, 2, 1, 1, 6);

      // closing stretch at full rate on both sides
      idle_on = 1'b0;
      repeat (500) send_random(3, 2, 2, 2, 2);

      wait_all_results();
      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
